@@ design/tlvcsp_pkg.sv @@
// Shared types, constants and codes for the TLV command stream parser.
package tlvcsp_pkg;

  localparam int unsigned OPCODE_W    = 16;
  localparam int unsigned LENGTH_W    = 8;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned FLOAT_OPCODE_COUNT = 3;

  localparam logic [LENGTH_W-1:0] MAX_VALUE_BYTES = 8'd8;
  localparam logic [LENGTH_W-1:0] FLOAT32_BYTES   = 8'd4;
  localparam logic [LENGTH_W-1:0] FLOAT64_BYTES   = 8'd8;

  // Event queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_OP_HI = 2'd0,
    PH_OP_LO = 2'd1,
    PH_SIZE  = 2'd2,
    PH_VALUE = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 3'd0,
    KIND_UNSIGNED = 3'd1,
    KIND_F32      = 3'd2,
    KIND_F64      = 3'd3,
    KIND_OVERSIZE = 3'd4
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FLOAT_FIRST  = 2'd0,
    REG_FLOAT_SECOND = 2'd1,
    REG_FLOAT_THIRD  = 2'd2,
    REG_FLOAT_ENABLE = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] stream_byte;
    logic              buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] record_opcode;
    logic [LENGTH_W-1:0] value_length;
    logic [VALUE_W-1:0]  record_value;
    logic [KIND_W-1:0]   value_kind;
    logic                truncated;
    logic                last_record;
  } out_word_t;

  // Record event handed from front to back; kind is resolved in the back
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [LENGTH_W-1:0] length;
    logic [VALUE_W-1:0]  value;
    logic                size_seen;
    logic                truncated;
    logic                last_record;
  } rec_event_t;

endpackage

@@ design/tlvcsp_front.sv @@
// Front end: byte-level record parser that produces record events.
module tlvcsp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  tlvcsp_pkg::in_word_t   item,
  output logic                   ev_valid,
  output tlvcsp_pkg::rec_event_t ev
);
  import tlvcsp_pkg::*;

  phase_t              phase, phase_next;
  logic [OPCODE_W-1:0] opcode_hold, opcode_hold_next;
  logic [LENGTH_W-1:0] length_hold, length_hold_next;
  logic [LENGTH_W-1:0] bytes_left, bytes_left_next;
  logic [VALUE_W-1:0]  value_acc, value_acc_next;
  logic [LENGTH_W-1:0] left_dec;
  logic [VALUE_W-1:0]  acc_shifted;
  logic                record_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OP_HI;
      opcode_hold <= '0;
      length_hold <= '0;
      bytes_left  <= '0;
      value_acc   <= '0;
    end else begin
      phase       <= phase_next;
      opcode_hold <= opcode_hold_next;
      length_hold <= length_hold_next;
      bytes_left  <= bytes_left_next;
      value_acc   <= value_acc_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    opcode_hold_next = opcode_hold;
    length_hold_next = length_hold;
    bytes_left_next  = bytes_left;
    value_acc_next   = value_acc;
    record_done      = 1'b0;
    ev_valid         = 1'b0;
    ev               = '0;

    left_dec    = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;
    acc_shifted = (length_hold <= MAX_VALUE_BYTES) ?
                  {value_acc[VALUE_W-BYTE_W-1:0], item.stream_byte} : value_acc;

    if (take) begin
      case (phase)
        PH_OP_HI: begin
          opcode_hold_next = {item.stream_byte, {BYTE_W{1'b0}}};
          phase_next       = PH_OP_LO;
          ev.opcode        = opcode_hold_next;
          ev.length        = length_hold;
          ev.truncated     = 1'b1;
          ev.last_record   = 1'b1;
          ev_valid         = item.buffer_end;
        end
        PH_OP_LO: begin
          opcode_hold_next = opcode_hold | {{BYTE_W{1'b0}}, item.stream_byte};
          phase_next       = PH_SIZE;
          ev.opcode        = opcode_hold_next;
          ev.length        = length_hold;
          ev.truncated     = 1'b1;
          ev.last_record   = 1'b1;
          ev_valid         = item.buffer_end;
        end
        PH_SIZE: begin
          length_hold_next = item.stream_byte;
          bytes_left_next  = item.stream_byte;
          value_acc_next   = '0;
          ev.opcode        = opcode_hold;
          ev.length        = item.stream_byte;
          ev.size_seen     = 1'b1;
          if (item.stream_byte == '0) begin
            // Empty value: the header alone completes the record
            ev.last_record = item.buffer_end;
            ev_valid       = 1'b1;
            record_done    = 1'b1;
          end else begin
            phase_next     = PH_VALUE;
            ev.truncated   = 1'b1;
            ev.last_record = 1'b1;
            ev_valid       = item.buffer_end;
          end
        end
        PH_VALUE: begin
          value_acc_next  = acc_shifted;
          bytes_left_next = left_dec;
          ev.opcode       = opcode_hold;
          ev.length       = length_hold;
          ev.size_seen    = 1'b1;
          ev.value        = (length_hold > MAX_VALUE_BYTES) ? '0 : acc_shifted;
          if (left_dec == '0) begin
            ev.last_record = item.buffer_end;
            ev_valid       = 1'b1;
            record_done    = 1'b1;
          end else begin
            ev.truncated   = 1'b1;
            ev.last_record = 1'b1;
            ev_valid       = item.buffer_end;
          end
        end
        default: begin
          phase_next = PH_OP_HI;
        end
      endcase

      // Drop all holds at a record end or a buffer end
      if (record_done || item.buffer_end) begin
        phase_next       = PH_OP_HI;
        opcode_hold_next = '0;
        length_hold_next = '0;
        bytes_left_next  = '0;
        value_acc_next   = '0;
      end
    end
  end

endmodule

@@ design/tlvcsp_queue.sv @@
// Short first-in first-out queue of record events between front and back.
module tlvcsp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  tlvcsp_pkg::rec_event_t wr_data,
  output logic                   q_full,
  output logic                   q_valid,
  input  logic                   rd_en,
  output tlvcsp_pkg::rec_event_t rd_data
);
  import tlvcsp_pkg::*;

  rec_event_t             slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign q_full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ design/tlvcsp_back.sv @@
// Back end: float opcode registers, value kind resolution and result register.
module tlvcsp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tlvcsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tlvcsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                q_valid,
  input  tlvcsp_pkg::rec_event_t              q_head,
  output logic                                q_pop,
  output logic                                empty,
  input  logic                                pop,
  output tlvcsp_pkg::out_word_t               result
);
  import tlvcsp_pkg::*;

  logic [OPCODE_W-1:0]           float_opcode [FLOAT_OPCODE_COUNT];
  logic [FLOAT_OPCODE_COUNT-1:0] float_enable;
  logic [FLOAT_OPCODE_COUNT-1:0] opcode_hit;
  logic                          is_float;
  kind_t                         kind;
  logic                          out_valid;
  out_word_t                     out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FLOAT_OPCODE_COUNT; i++) begin
        float_opcode[i] <= '0;
      end
      float_enable <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FLOAT_FIRST:  float_opcode[0] <= cfg_data[OPCODE_W-1:0];
        REG_FLOAT_SECOND: float_opcode[1] <= cfg_data[OPCODE_W-1:0];
        REG_FLOAT_THIRD:  float_opcode[2] <= cfg_data[OPCODE_W-1:0];
        REG_FLOAT_ENABLE: float_enable    <= cfg_data[FLOAT_OPCODE_COUNT-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < FLOAT_OPCODE_COUNT; i++) begin
      opcode_hit[i] = float_enable[i] && (q_head.opcode == float_opcode[i]);
    end
    is_float = |opcode_hit;

    if (!q_head.size_seen || q_head.length == '0) begin
      kind = KIND_NONE;
    end else if (q_head.length > MAX_VALUE_BYTES) begin
      kind = KIND_OVERSIZE;
    end else if (is_float && q_head.length == FLOAT32_BYTES) begin
      kind = KIND_F32;
    end else if (is_float && q_head.length == FLOAT64_BYTES) begin
      kind = KIND_F64;
    end else begin
      kind = KIND_UNSIGNED;
    end
  end

  // Advance the queue whenever the result register is free or being drained
  assign q_pop = q_valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_word.record_opcode <= q_head.opcode;
      out_word.value_length  <= q_head.length;
      out_word.record_value  <= q_head.value;
      out_word.value_kind    <= kind;
      out_word.truncated     <= q_head.truncated;
      out_word.last_record   <= q_head.last_record;
    end
  end

  assign empty  = !out_valid;
  assign result = out_word;

endmodule

@@ design/tlv_command_stream_parser.sv @@
// Top level of the type-length-value command stream parser.
//
// Takes one stream byte per clock and reports one word per record: the
// 16-bit big-endian opcode, the size byte, the value bytes gathered
// big-endian and right aligned into 64 bits, and a kind (0 none,
// 1 unsigned, 2 float32, 3 float64, 4 oversize). A 4 or 8 byte value is
// a float when its opcode matches one of the three float opcode registers
// whose bit is set in the enable register. Sizes above 8 have their bytes
// counted and dropped and report value 0. A buffer end inside a record
// reports the partial record with truncated and last_record set, and the
// parser starts over at the next byte. Input and output both look like a
// queue: push/full on the byte side, empty/pop on the result side. A byte
// is accepted every clock while full is low; full rises only when four
// record events sit in the internal queue behind an unpopped result.
// A record's event passes through the internal queue and the result word;
// a new result can be popped every clock while events wait. Configuration
// is always ready and should be written only while the parser is idle.
module tlv_command_stream_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  tlvcsp_pkg::in_word_t               item,
  output logic                               empty,
  input  logic                               pop,
  output tlvcsp_pkg::out_word_t              result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlvcsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlvcsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tlvcsp_pkg::*;

  logic       take;
  logic       ev_valid;
  rec_event_t ev;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  rec_event_t q_head;

  // Accept a word whenever the event queue has room
  assign full = q_full;
  assign take = push && !q_full;

  tlvcsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  tlvcsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ev_valid),
    .wr_data (ev),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_en   (q_pop),
    .rd_data (q_head)
  );

  tlvcsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

@@ design/tlvcsp_checker.sv @@
// Port-level checker for the TLV command stream parser, with its bind.
module tlvcsp_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  push,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input tlvcsp_pkg::out_word_t result
);
  import tlvcsp_pkg::*;

  // Reset leaves no result pending and room for input
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("result or full asserted after reset");

  // A waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // Backpressure only builds up behind a pending result
  a_full_needs_result: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("full asserted with no result pending");

  // No result appears without a recent accepted word
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (empty && $past(empty) && !$past(push && !full)) |=> empty)
    else $error("result appeared without input");

endmodule

bind tlv_command_stream_parser tlvcsp_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

@@ tb/sv/tlv_command_stream_parser_tb.sv @@
// Self-checking testbench for the TLV command stream parser.
`timescale 1ns / 1ps

import tlvcsp_pkg::*;

class record_tracker;
  // float opcode registers as last written
  logic [OPCODE_W-1:0] float_op [FLOAT_OPCODE_COUNT];
  logic [2:0]          float_en;

  // parse state, mirrors the block's record assembly
  phase_t              phase;
  logic [OPCODE_W-1:0] op_hold;
  logic [LENGTH_W-1:0] len_hold;
  logic [LENGTH_W-1:0] left;
  logic [VALUE_W-1:0]  acc;

  out_word_t records_due [$];
  int        mismatches;
  int        bytes_taken;

  function new();
    foreach (float_op[i]) float_op[i] = '0;
    float_en    = '0;
    mismatches  = 0;
    bytes_taken = 0;
    clear();
  endfunction

  function void clear();
    phase    = PH_OP_HI;
    op_hold  = '0;
    len_hold = '0;
    left     = '0;
    acc      = '0;
  endfunction

  function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FLOAT_FIRST:  float_op[0] = data;
      REG_FLOAT_SECOND: float_op[1] = data;
      REG_FLOAT_THIRD:  float_op[2] = data;
      REG_FLOAT_ENABLE: float_en = data[2:0];
      default: ;
    endcase
  endfunction

  function kind_t kind_for();
    logic is_float;
    is_float = 1'b0;
    if (len_hold == 0) return KIND_NONE;
    if (len_hold > MAX_VALUE_BYTES) return KIND_OVERSIZE;
    for (int i = 0; i < FLOAT_OPCODE_COUNT; i++)
      if (float_en[i] && op_hold == float_op[i]) is_float = 1'b1;
    if (is_float && len_hold == FLOAT32_BYTES) return KIND_F32;
    if (is_float && len_hold == FLOAT64_BYTES) return KIND_F64;
    return KIND_UNSIGNED;
  endfunction

  function void queue_record(kind_t kind, logic trunc, logic last);
    out_word_t r;
    r.record_opcode = op_hold;
    r.value_length  = len_hold;
    r.record_value  = (len_hold > MAX_VALUE_BYTES) ? '0 : acc;
    r.value_kind    = kind;
    r.truncated     = trunc;
    r.last_record   = last;
    records_due.push_back(r);
  endfunction

  // Note one accepted input word and queue the record it completes, if any.
  function void take_byte(in_word_t w);
    logic [BYTE_W-1:0] b;
    logic              fin;
    b   = w.stream_byte;
    fin = w.buffer_end;
    bytes_taken++;
    case (phase)
      PH_OP_HI: begin
        op_hold = {b, 8'h00};
        phase   = PH_OP_LO;
        if (fin) queue_record(KIND_NONE, 1'b1, 1'b1);
      end
      PH_OP_LO: begin
        op_hold[7:0] = b;
        phase        = PH_SIZE;
        if (fin) queue_record(KIND_NONE, 1'b1, 1'b1);
      end
      PH_SIZE: begin
        len_hold = b;
        left     = b;
        acc      = '0;
        if (b == 0) begin
          queue_record(KIND_NONE, 1'b0, fin);
          clear();
        end else begin
          phase = PH_VALUE;
          if (fin) queue_record(kind_for(), 1'b1, 1'b1);
        end
      end
      default: begin
        if (len_hold <= MAX_VALUE_BYTES) acc = {acc[VALUE_W-9:0], b};
        if (left > 0) left = left - 1'b1;
        if (left == 0) begin
          queue_record(kind_for(), 1'b0, fin);
          clear();
        end else if (fin) begin
          queue_record(kind_for(), 1'b1, 1'b1);
        end
      end
    endcase
    if (fin) clear();
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one popped result word with the oldest queued record.
  function void match_record(out_word_t r);
    out_word_t want;
    if (records_due.size() == 0) begin
      $display("%0t: unexpected result, expected none got %h", $time, r);
      mismatches++;
      return;
    end
    want = records_due.pop_front();
    check_field("record_opcode", want.record_opcode, r.record_opcode);
    check_field("value_length", want.value_length, r.value_length);
    check_field("record_value", want.record_value, r.record_value);
    check_field("value_kind", want.value_kind, r.value_kind);
    check_field("truncated", want.truncated, r.truncated);
    check_field("last_record", want.last_record, r.last_record);
  endfunction

  function int pending();
    return records_due.size();
  endfunction
endclass

module tlv_command_stream_parser_tb;

  localparam int BYTE_TARGET  = 1600;
  localparam int PHASES       = 5;
  localparam int SETTLE_CYCLES = 8;

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  in_word_t               item;
  logic                   empty;
  logic                   pop;
  out_word_t              result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  record_tracker book;

  // idle stretches for each side: a stretch either draws gaps or runs flat out
  int push_stretch = 0;
  bit push_calm    = 0;
  int pop_stretch  = 0;
  bit pop_calm     = 0;

  tlv_command_stream_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Draw the wait before the next word; renew the stretch when it runs out.
  function automatic int next_gap(inout int stretch, inout bit calm);
    if (stretch == 0) begin
      stretch = $urandom_range(20, 80);
      calm    = ($urandom_range(0, 3) == 0);
    end
    stretch--;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Offer one input word after a random gap; hold it until the block takes it.
  task automatic send_byte(logic [BYTE_W-1:0] b, logic fin);
    int       gap;
    in_word_t w;
    gap           = next_gap(push_stretch, push_calm);
    w.stream_byte = b;
    w.buffer_end  = fin;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
    book.take_byte(w);
  endtask

  // Send the first count bytes of a record; fill < 0 means random value bytes.
  // The last byte sent carries buffer_end when fin_last is set.
  task automatic send_record(logic [OPCODE_W-1:0] op, int size, int count,
                             bit fin_last, int fill);
    logic [BYTE_W-1:0] b;
    for (int k = 0; k < count; k++) begin
      if (k == 0)      b = op[15:8];
      else if (k == 1) b = op[7:0];
      else if (k == 2) b = size[7:0];
      else if (fill < 0) b = $urandom_range(0, 255);
      else             b = fill[7:0];
      send_byte(b, fin_last && (k == count - 1));
    end
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, data);
  endtask

  // Program all float registers; only called with nothing in flight.
  task automatic write_floats(logic [15:0] f1, logic [15:0] f2, logic [15:0] f3,
                              logic [15:0] en);
    write_reg(REG_FLOAT_FIRST, f1);
    write_reg(REG_FLOAT_SECOND, f2);
    write_reg(REG_FLOAT_THIRD, f3);
    write_reg(REG_FLOAT_ENABLE, en);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every queued record, then let the pipeline go quiet.
  task automatic settle();
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random record: mostly well formed, some cut short, a little noise.
  task automatic random_record();
    logic [OPCODE_W-1:0] op;
    int size;
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick < 4)      op = book.float_op[$urandom_range(0, FLOAT_OPCODE_COUNT - 1)];
    else if (pick < 5) op = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
    else               op = $urandom_range(0, 65535);

    pick = $urandom_range(0, 99);
    if (pick < 50)      size = ($urandom_range(0, 1) == 0) ? 4 : 8;
    else if (pick < 80) size = $urandom_range(0, 8);
    else if (pick < 95) size = $urandom_range(9, 16);
    else if (pick < 99) size = $urandom_range(17, 40);
    else                size = $urandom_range(200, 255);

    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      send_record(op, size, size + 3, 1'b0, -1);
    end else if (pick < 88) begin
      send_record(op, size, size + 3, 1'b1, -1);
    end else if (pick < 96) begin
      // cut the record short with a buffer end
      send_record(op, size, $urandom_range(1, size + 2), 1'b1, -1);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
    end
  endtask

  // Byte side: reset, directed records, then random phases under several
  // register settings, then drain and report.
  initial begin
    logic [15:0] f1;
    logic [15:0] f2;
    logic [15:0] f3;
    logic [2:0]  en;
    book      = new();
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FLOAT_FIRST;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every kind, every truncation point, extreme opcodes and sizes.
    write_floats(16'h1234, 16'hFFFF, 16'h0000, 16'h0007);
    send_record(16'h1234, 4, 7, 1'b0, -1);     // float32 on first register
    send_record(16'hFFFF, 8, 11, 1'b0, 255);   // float64, all ones
    send_record(16'h0000, 0, 3, 1'b0, 0);      // empty value
    send_record(16'h0000, 8, 11, 1'b0, 0);     // float64 on third, all zeros
    send_record(16'h1234, 3, 6, 1'b0, -1);     // float opcode, odd size
    send_record(16'h1234, 8, 11, 1'b0, -1);
    send_record(16'hFFFF, 4, 7, 1'b0, -1);
    send_record(16'hABCD, 9, 12, 1'b0, -1);    // just over the value limit
    send_record(16'h5A5A, 1, 4, 1'b1, -1);     // buffer end on completing byte
    send_record(16'h00FF, 0, 3, 1'b1, 0);      // buffer end on empty record
    send_record(16'hFF00, 2, 1, 1'b1, 0);      // end after opcode high byte
    send_record(16'h8001, 2, 2, 1'b1, 0);      // end after opcode low byte
    send_record(16'h1234, 4, 3, 1'b1, 0);      // end right after size byte
    send_record(16'hFFFF, 8, 6, 1'b1, -1);     // end inside value bytes
    send_record(16'hC3C3, 255, 5, 1'b1, -1);   // largest size, cut short
    send_record(16'h7777, 12, 15, 1'b1, -1);   // oversize ending the buffer
    push <= 1'b0;
    settle();

    for (int p = 0; p < PHASES; p++) begin
      f1 = $urandom_range(0, 65535);
      f2 = $urandom_range(0, 65535);
      f3 = $urandom_range(0, 65535);
      en = $urandom_range(0, 7);
      case (p)
        0: write_floats(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: write_floats(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0007);
        2: write_floats(f1, f2, f3, {13'($urandom), en});  // upper bits ignored
        3: write_floats(f1, f2, f3, 16'h0007);
        default: write_floats(f1, f1, f3, {13'h0000, en});
      endcase
      while (book.bytes_taken < BYTE_TARGET * (p + 1) / PHASES) random_record();
      // close the buffer so the parser is back at the start of a record
      send_byte($urandom_range(0, 255), 1'b1);
      push <= 1'b0;
      settle();
    end

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: pop with random stalls and check each word taken.
  initial begin
    int gap;
    pop <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = next_gap(pop_stretch, pop_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      book.match_record(result);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
